// File: src/dqbf_pkg.sv
// ----------------------------------------------------------------------------
// dqbf_pkg
// Shared types, constants and helpers for the dotted-quad bogon filter.
// ----------------------------------------------------------------------------
package dqbf_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned ADDR_W  = 32;

    localparam logic [COUNT_W-1:0] ROW_LIMIT_RESET = 16'd5000;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

    localparam logic [1:0] LAST_OCTET_INDEX = 2'd3;
    localparam logic [1:0] MAX_DIGITS       = 2'd3;

    typedef enum logic [1:0] {
        STATUS_NOT_ADDR = 2'd0,
        STATUS_RESERVED = 2'd1,
        STATUS_OVER_LIM = 2'd2,
        STATUS_ACCEPTED = 2'd3
    } dqbf_status_t;

    // One byte step presented to the parser.
    typedef struct packed {
        logic              step;
        logic              line_end;
        logic [CHAR_W-1:0] ch;
    } dqbf_step_t;

    // Line verdict from the parser, valid when a line end steps in.
    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] addr;
    } dqbf_verdict_t;

    function automatic logic is_reserved(input logic [7:0] a, input logic [7:0] b);
        logic res;
        res = 1'b0;
        if (a == 8'd0 || a == 8'd10 || a == 8'd127 || a >= 8'd224)
            res = 1'b1;
        if (a == 8'd169 && b == 8'd254)
            res = 1'b1;
        if (a == 8'd172 && b >= 8'd16 && b <= 8'd31)
            res = 1'b1;
        if (a == 8'd192 && b == 8'd168)
            res = 1'b1;
        if (a == 8'd100 && b >= 8'd64 && b <= 8'd127)
            res = 1'b1;
        return res;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 16'd1;
    endfunction

endpackage

// File: src/ipv4_dotted_quad_bogon_filter.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_bogon_filter
// Strict dotted-quad IPv4 line parser with reserved-range filter and totals.
// ----------------------------------------------------------------------------
// Text comes in one byte per input word; a word with line_end set closes the
// line and yields exactly one output word, plain bytes yield none. The block
// takes one input word per cycle at full rate unless stalled: a word is
// captured in an input register, from which it updates the parser state
// and, on a line end, the output register. The only stall is a line end that
// meets an output word not yet taken; byte words pass through even then.
// line_status: 0 not an address, 1 reserved and dropped, 2 over row_limit,
// 3 accepted. address is zero for status 0. The three totals saturate at
// 65535. row_limit (reset 5000) is written through cfg_write_en/cfg_write_data
// and should change only while the block is idle.
module ipv4_dotted_quad_bogon_filter
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        line_end,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  line_status,
    output logic [31:0] address,
    output logic [15:0] seen_count,
    output logic [15:0] dropped_count,
    output logic [15:0] emitted_count
);
    import dqbf_pkg::*;

    // config
    logic [COUNT_W-1:0] row_limit_reg;

    // input register stage
    logic              s1_valid_reg, s1_valid_next;
    logic [CHAR_W-1:0] s1_ch_reg;
    logic              s1_end_reg;

    // running totals
    logic [COUNT_W-1:0] seen_reg,    seen_next;
    logic [COUNT_W-1:0] dropped_reg, dropped_next;
    logic [COUNT_W-1:0] emitted_reg, emitted_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    dqbf_status_t       status_reg,    status_next;
    logic [ADDR_W-1:0]  addr_reg,      addr_next;

    logic               out_free;
    logic               s1_advance;
    logic               in_fire;
    dqbf_step_t         pstep;
    dqbf_verdict_t      verdict;

    // A byte word never needs the output; a line end waits for a free slot.
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && (!s1_end_reg || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    assign pstep.step     = s1_advance;
    assign pstep.line_end = s1_end_reg;
    assign pstep.ch       = s1_ch_reg;

    dqbf_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_in (pstep),
        .verdict (verdict)
    );

    // Line judgement: bogon check, then row limit.
    always_comb
    begin
        seen_next      = seen_reg;
        dropped_next   = dropped_reg;
        emitted_next   = emitted_reg;
        status_next    = status_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (s1_advance && s1_end_reg)
        begin
            out_valid_next = 1'b1;
            status_next    = STATUS_NOT_ADDR;
            addr_next      = '0;
            if (verdict.ok)
            begin
                addr_next = verdict.addr;
                seen_next = sat_inc(seen_reg);
                priority if (is_reserved(verdict.addr[31:24], verdict.addr[23:16]))
                begin
                    dropped_next = sat_inc(dropped_reg);
                    status_next  = STATUS_RESERVED;
                end
                else if (emitted_reg >= row_limit_reg)
                    status_next = STATUS_OVER_LIM;
                else
                begin
                    emitted_next = sat_inc(emitted_reg);
                    status_next  = STATUS_ACCEPTED;
                end
            end
        end
    end

    assign s1_valid_next = in_fire || (s1_valid_reg && !s1_advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_limit_reg <= ROW_LIMIT_RESET;
            s1_valid_reg  <= 1'b0;
            seen_reg      <= '0;
            dropped_reg   <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= STATUS_NOT_ADDR;
        end
        else
        begin
            if (cfg_write_en)
                row_limit_reg <= cfg_write_data;
            s1_valid_reg  <= s1_valid_next;
            seen_reg      <= seen_next;
            dropped_reg   <= dropped_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ch_reg  <= ch;
            s1_end_reg <= line_end;
        end
        addr_reg <= addr_next;
    end

    // Totals are captured alongside the result word, so they track it.
    assign out_valid     = out_valid_reg;
    assign line_status   = status_reg;
    assign address       = addr_reg;
    assign seen_count    = seen_reg;
    assign dropped_count = dropped_reg;
    assign emitted_count = emitted_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // Input only stalls behind a pending output word.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg)
        else $error("input stalled with output register empty");

    // Every drop or emit is also counted as seen.
    a_totals_order: assert property (@(posedge clk) disable iff (!rst_n)
        (dropped_reg <= seen_reg) && (emitted_reg <= seen_reg))
        else $error("dropped/emitted total exceeds seen total");

    // A non-address line reports a zero address.
    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STATUS_NOT_ADDR) |-> (addr_reg == '0))
        else $error("nonzero address on non-address line");

    // An accepted address never lies in the zero network.
    a_accept_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STATUS_ACCEPTED) |-> (addr_reg[31:24] != 8'd0))
        else $error("accepted address in reserved zero network");

endmodule

// File: src/dqbf_parser.sv
// ----------------------------------------------------------------------------
// dqbf_parser
// Per-line dotted-quad parser state; one byte per step, cleared at line end.
// ----------------------------------------------------------------------------
module dqbf_parser
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dqbf_pkg::dqbf_step_t   step_in,
    output dqbf_pkg::dqbf_verdict_t verdict
);
    import dqbf_pkg::*;

    logic [7:0]  octet_value_reg, octet_value_next;
    logic [1:0]  digit_count_reg, digit_count_next;
    logic [1:0]  octet_index_reg, octet_index_next;
    logic        line_bad_reg,    line_bad_next;
    logic        after_dot_reg,   after_dot_next;
    logic [23:0] upper_octets_reg, upper_octets_next;

    logic        is_digit;
    logic [11:0] acc;   // octet * 10 + digit, up to 2559

    assign is_digit = (step_in.ch >= CHAR_ZERO) && (step_in.ch <= CHAR_NINE);
    assign acc = {1'b0, octet_value_reg, 3'b000} + {3'b000, octet_value_reg, 1'b0}
               + {8'd0, step_in.ch[3:0] - CHAR_ZERO[3:0]};

    assign verdict.ok   = !line_bad_reg && (octet_index_reg == LAST_OCTET_INDEX)
                        && (digit_count_reg != 2'd0) && !after_dot_reg;
    assign verdict.addr = {upper_octets_reg, octet_value_reg};

    always_comb
    begin
        octet_value_next  = octet_value_reg;
        digit_count_next  = digit_count_reg;
        octet_index_next  = octet_index_reg;
        line_bad_next     = line_bad_reg;
        after_dot_next    = after_dot_reg;
        upper_octets_next = upper_octets_reg;
        if (step_in.step)
        begin
            if (step_in.line_end)
            begin
                octet_value_next  = '0;
                digit_count_next  = '0;
                octet_index_next  = '0;
                line_bad_next     = 1'b0;
                after_dot_next    = 1'b0;
                upper_octets_next = '0;
            end
            else if (!line_bad_reg)
            begin
                priority if (is_digit)
                begin
                    if (digit_count_reg == MAX_DIGITS || acc > 12'd255)
                        line_bad_next = 1'b1;
                    else
                    begin
                        octet_value_next = acc[7:0];
                        digit_count_next = digit_count_reg + 2'd1;
                        after_dot_next   = 1'b0;
                    end
                end
                else if (step_in.ch == CHAR_DOT)
                begin
                    if (digit_count_reg == 2'd0 || octet_index_reg == LAST_OCTET_INDEX)
                        line_bad_next = 1'b1;
                    else
                    begin
                        upper_octets_next = {upper_octets_reg[15:0], octet_value_reg};
                        octet_index_next  = octet_index_reg + 2'd1;
                        octet_value_next  = '0;
                        digit_count_next  = '0;
                        after_dot_next    = 1'b1;
                    end
                end
                else
                    line_bad_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octet_value_reg  <= '0;
            digit_count_reg  <= '0;
            octet_index_reg  <= '0;
            line_bad_reg     <= 1'b0;
            after_dot_reg    <= 1'b0;
            upper_octets_reg <= '0;
        end
        else
        begin
            octet_value_reg  <= octet_value_next;
            digit_count_reg  <= digit_count_next;
            octet_index_reg  <= octet_index_next;
            line_bad_reg     <= line_bad_next;
            after_dot_reg    <= after_dot_next;
            upper_octets_reg <= upper_octets_next;
        end
    end

endmodule
